// ===== hw/rtl/ddp_pkg.sv =====
package ddp_pkg;

   localparam int ROW_FIELD_W = 18;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 11;
   localparam int CYCLE_W     = 64;
   localparam int WCOUNT_W    = 11;

   localparam logic [WCOUNT_W-1:0] WCOUNT_MAX = 11'd2047;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCESS_LATENCY  = 4'd0,
      CSR_BURST_CYCLES    = 4'd1,
      CSR_ROW_MISS_DELAY  = 4'd2,
      CSR_MISS_BANK_BUSY  = 4'd3,
      CSR_HIT_BANK_BUSY   = 4'd4,
      CSR_WRITE_HIGH_MARK = 4'd5,
      CSR_WRITE_LOW_MARK  = 4'd6,
      CSR_DRAIN_OVERHEAD  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]          access_latency;
      logic [5:0]          burst_cycles;
      logic [9:0]          row_miss_delay;
      logic [9:0]          miss_bank_busy;
      logic [7:0]          hit_bank_busy;
      logic [WCOUNT_W-1:0] write_high_mark;
      logic [WCOUNT_W-1:0] write_low_mark;
      logic [7:0]          drain_overhead;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      access_latency:  8'd22,
      burst_cycles:    6'd4,
      row_miss_delay:  10'd26,
      miss_bank_busy:  10'd44,
      hit_bank_busy:   8'd6,
      write_high_mark: 11'd51,
      write_low_mark:  11'd32,
      drain_overhead:  8'd20
   };

   typedef struct packed {
      logic                   mode;
      logic [CYCLE_W-1:0]     now;
      logic                   rank_index;
      logic [1:0]             group_index;
      logic [1:0]             bank_index;
      logic [ROW_FIELD_W-1:0] row_index;
   } req_type;

   typedef struct packed {
      logic [CYCLE_W-1:0] depart_cycle;
      logic               row_hit;
   } rsp_type;

   function automatic logic [CYCLE_W-1:0] sat_add(input logic [CYCLE_W-1:0] a,
                                                   input logic [CYCLE_W-1:0] b);
      logic [CYCLE_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CYCLE_W] ? {CYCLE_W{1'b1}} : sum[CYCLE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/ddp_core.sv =====
module ddp_core #(
   parameter int RANKS           = 2,
   parameter int GROUPS          = 4,
   parameter int BANKS_PER_GROUP = 4,
   parameter int ROW_BITS        = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  ddp_pkg::req_type item,
   input  ddp_pkg::cfg_type cfg,
   output ddp_pkg::rsp_type result
);

   localparam int NUM_BANKS = RANKS * GROUPS * BANKS_PER_GROUP;
   localparam int FLAT_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int RAW_MAX   = (GROUPS + 3) * BANKS_PER_GROUP + 3;
   localparam int RAW_W     = $clog2(RAW_MAX + 1);
   localparam int ROW_W     = (ROW_BITS < ddp_pkg::ROW_FIELD_W) ? ROW_BITS
                                                                : ddp_pkg::ROW_FIELD_W;
   localparam int CW        = ddp_pkg::CYCLE_W;
   localparam int WW        = ddp_pkg::WCOUNT_W;

   logic [FLAT_W-1:0] flat_tbl [2**RAW_W];

   for (genvar i = 0; i < 2**RAW_W; i++) begin : g_flat
      assign flat_tbl[i] = FLAT_W'(i % NUM_BANKS);
   end

   logic              bank_valid_ff [NUM_BANKS];
   logic [ROW_W-1:0]  open_row_ff   [NUM_BANKS];
   logic [CW-1:0]     bank_ready_ff [NUM_BANKS];
   logic [CW-1:0]     bus_free_ff;
   logic [CW-1:0]     bus_free_in;
   logic [WW-1:0]     wcount_ff;
   logic [WW-1:0]     wcount_in;

   logic [RAW_W-1:0]  raw_idx;
   logic [FLAT_W-1:0] flat;
   logic              sel_valid;
   logic              hit;
   logic [CW-1:0]     sel_ready;
   logic [CW-1:0]     issue;
   logic [9:0]        bank_busy;
   logic [CW-1:0]     new_ready;
   logic [7:0]        base;
   logic [10:0]       lead;
   logic [CW-1:0]     ideal;
   logic [CW-1:0]     rd_bus_at;
   logic [CW-1:0]     rd_depart;
   logic [WW-1:0]     wcount_inc;
   logic              drain_on;
   logic [WW-1:0]     drain;
   logic [16:0]       drain_burst;
   logic [17:0]       drain_busy;
   logic [CW-1:0]     wr_bus_at;
   logic [CW-1:0]     wr_bus;
   logic [CW-1:0]     wr_depart;
   logic              is_write;

   always_comb begin
      is_write  = (item.mode == ddp_pkg::MODE_WRITE);
      raw_idx   = RAW_W'((RAW_W'(item.rank_index) * RAW_W'(GROUPS) + RAW_W'(item.group_index))
                         * RAW_W'(BANKS_PER_GROUP) + RAW_W'(item.bank_index));
      flat      = flat_tbl[raw_idx];
      sel_valid = bank_valid_ff[flat];
      hit       = sel_valid && (open_row_ff[flat] == item.row_index[ROW_W-1:0]);
      sel_ready = sel_valid ? bank_ready_ff[flat] : '0;
      issue     = (item.now > sel_ready) ? item.now : sel_ready;
      bank_busy = hit ? 10'(cfg.hit_bank_busy) : cfg.miss_bank_busy;
      new_ready = ddp_pkg::sat_add(issue, CW'(bank_busy));
      base      = (cfg.access_latency > 8'(cfg.burst_cycles))
                  ? cfg.access_latency - 8'(cfg.burst_cycles) : '0;
      lead      = hit ? 11'(base) : 11'(base) + 11'(cfg.row_miss_delay);
      ideal     = ddp_pkg::sat_add(issue, CW'(lead));
      rd_bus_at = (ideal > bus_free_ff) ? ideal : bus_free_ff;
      rd_depart = ddp_pkg::sat_add(rd_bus_at, CW'(cfg.burst_cycles));

      wcount_inc  = (wcount_ff == ddp_pkg::WCOUNT_MAX) ? wcount_ff : wcount_ff + WW'(1);
      drain_on    = (wcount_inc >= cfg.write_high_mark);
      drain       = ((WW+1)'(wcount_inc) > (WW+1)'(cfg.write_low_mark) + (WW+1)'(1))
                    ? wcount_inc - cfg.write_low_mark : WW'(1);
      drain_burst = 17'(drain) * 17'(cfg.burst_cycles);
      drain_busy  = 18'(drain_burst) + 18'(cfg.drain_overhead);
      wr_bus_at   = (bus_free_ff > item.now) ? bus_free_ff : item.now;
      wr_bus      = ddp_pkg::sat_add(wr_bus_at, CW'(drain_busy));
      wr_depart   = ddp_pkg::sat_add(item.now, CW'(cfg.access_latency));

      bus_free_in = bus_free_ff;
      wcount_in   = wcount_ff;
      if (fire) begin
         if (is_write) begin
            wcount_in = drain_on ? wcount_inc - drain : wcount_inc;
            if (drain_on) begin
               bus_free_in = wr_bus;
            end
         end else begin
            bus_free_in = rd_depart;
         end
      end

      result.depart_cycle = is_write ? wr_depart : rd_depart;
      result.row_hit      = !is_write && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_free_ff <= '0;
         wcount_ff   <= '0;
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank_valid_ff[i] <= 1'b0;
         end
      end else begin
         bus_free_ff <= bus_free_in;
         wcount_ff   <= wcount_in;
         if (fire && !is_write) begin
            bank_valid_ff[flat] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !is_write) begin
         open_row_ff[flat]   <= item.row_index[ROW_W-1:0];
         bank_ready_ff[flat] <= new_ready;
      end
   end

endmodule

// ===== hw/rtl/dram_departure_predictor_top.sv =====
// Predicts the departure cycle of each DRAM request under an open-page policy. One item is
// taken per clock while the output is not stalled: the item is held in an input register,
// the bank, bus and write-buffer state is read and updated in the cycle it is processed,
// and the result is held in an output register until taken. The rate of one item per cycle
// rests on the update of the data bus free time, which every item reads. Reset clears the
// per-bank open-row valid bits at once, so no clearing pass is needed. The csr port writes
// configuration registers; the user must do so only while no item is in flight (unenforced).
module dram_departure_predictor_top #(
   parameter int RANKS           = 2,
   parameter int GROUPS          = 4,
   parameter int BANKS_PER_GROUP = 4,
   parameter int ROW_BITS        = 18
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [ddp_pkg::CYCLE_W-1:0]        req_now,
   input  logic                               req_rank_index,
   input  logic [1:0]                         req_group_index,
   input  logic [1:0]                         req_bank_index,
   input  logic [ddp_pkg::ROW_FIELD_W-1:0]    req_row_index,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ddp_pkg::CYCLE_W-1:0]        rsp_depart_cycle,
   output logic                               rsp_row_hit,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ddp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ddp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ddp_pkg::cfg_type cfg_ff;
   ddp_pkg::cfg_type cfg_in;
   ddp_pkg::req_type item_ff;
   ddp_pkg::req_type item_in;
   ddp_pkg::rsp_type rsp_ff;
   ddp_pkg::rsp_type rsp_in;
   ddp_pkg::rsp_type core_result;
   logic             item_valid_ff;
   logic             item_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             out_free;
   logic             fire;
   logic             req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ddp_pkg::CSR_ACCESS_LATENCY:  cfg_in.access_latency  = csr_wdata[7:0];
            ddp_pkg::CSR_BURST_CYCLES:    cfg_in.burst_cycles    = csr_wdata[5:0];
            ddp_pkg::CSR_ROW_MISS_DELAY:  cfg_in.row_miss_delay  = csr_wdata[9:0];
            ddp_pkg::CSR_MISS_BANK_BUSY:  cfg_in.miss_bank_busy  = csr_wdata[9:0];
            ddp_pkg::CSR_HIT_BANK_BUSY:   cfg_in.hit_bank_busy   = csr_wdata[7:0];
            ddp_pkg::CSR_WRITE_HIGH_MARK: cfg_in.write_high_mark = csr_wdata[10:0];
            ddp_pkg::CSR_WRITE_LOW_MARK:  cfg_in.write_low_mark  = csr_wdata[10:0];
            ddp_pkg::CSR_DRAIN_OVERHEAD:  cfg_in.drain_overhead  = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      fire      = item_valid_ff && out_free;
      req_stall = item_valid_ff && !out_free;
      req_take  = req_valid && !req_stall;

      item_valid_in = req_take || (item_valid_ff && !fire);
      item_in       = item_ff;
      if (req_take) begin
         item_in.mode        = req_mode;
         item_in.now         = req_now;
         item_in.rank_index  = req_rank_index;
         item_in.group_index = req_group_index;
         item_in.bank_index  = req_bank_index;
         item_in.row_index   = req_row_index;
      end

      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      rsp_in       = fire ? core_result : rsp_ff;
   end

   ddp_core #(
      .RANKS           (RANKS),
      .GROUPS          (GROUPS),
      .BANKS_PER_GROUP (BANKS_PER_GROUP),
      .ROW_BITS        (ROW_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= ddp_pkg::CFG_RESET;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_depart_cycle = rsp_ff.depart_cycle;
   assign rsp_row_hit      = rsp_ff.row_hit;

`ifndef SYNTH
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held item and a blocked result");

   a_fire_delivers: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("item processed but no result presented");

   a_depart_not_early: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_depart_cycle >= $past(item_ff.now)))
      else $error("departure cycle earlier than admission cycle");

   a_write_no_hit: assert property (@(posedge clock) disable iff (reset)
      (fire && item_ff.mode == ddp_pkg::MODE_WRITE) |=> !rsp_row_hit)
      else $error("write item reported a row hit");
`endif

endmodule
